>>> rtl/sbsm_pkg.sv
// ----------------------------------------------------------------------------
// sbsm_pkg: shared definitions for the serial bank-switch mapper
// Request codes, register indexes, field widths and the bank mask helper.
// ----------------------------------------------------------------------------
package sbsm_pkg;

  // Field widths
  localparam int TYPE_W   = 2;
  localparam int ADDR_W   = 16;
  localparam int VALUE_W  = 8;
  localparam int OFFSET_W = 19;
  localparam int BANK_W   = 5;
  localparam int LOG_W    = 3;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 3;

  typedef logic [TYPE_W-1:0]      req_code_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [BANK_W-1:0]      bank_t;

  // Request codes
  localparam req_code_t REQ_PRG_READ  = 2'd0;
  localparam req_code_t REQ_PRG_WRITE = 2'd1;
  localparam req_code_t REQ_CHR_READ  = 2'd2;

  // Register indexes
  localparam cfg_index_t CFG_PRG_BANKS_LOG2 = 2'd0;
  localparam cfg_index_t CFG_CHR_BANKS_LOG2 = 2'd1;
  localparam cfg_index_t CFG_CHR_PRESENT    = 2'd2;

  // Control register bits ORed in by a shifter reset write; also the reset value
  localparam bank_t CTRL_PRG_MODE3 = 5'h0C;
  localparam logic [LOG_W-1:0] LOG2_MAX = 3'd5;

  // Bank mask from a bank-count log, saturated at the largest size
  function automatic bank_t bank_limit(logic [LOG_W-1:0] lg);
    logic [LOG_W-1:0] lg_sat;
    lg_sat = (lg > LOG2_MAX) ? LOG2_MAX : lg;
    return BANK_W'((6'd1 << lg_sat) - 6'd1);
  endfunction

endpackage

>>> rtl/sbsm_req_if.sv
// ----------------------------------------------------------------------------
// sbsm_req_if: bus request channel
// Valid/ready channel carrying one program or pattern bus request.
// ----------------------------------------------------------------------------
interface sbsm_req_if;
  import sbsm_pkg::*;

  logic                valid;
  logic                ready;
  logic [TYPE_W-1:0]   req_type;
  logic [ADDR_W-1:0]   bus_address;
  logic [VALUE_W-1:0]  write_value;

  modport source (output valid, req_type, bus_address, write_value, input ready);
  modport sink   (input valid, req_type, bus_address, write_value, output ready);
endinterface

>>> rtl/sbsm_rsp_if.sv
// ----------------------------------------------------------------------------
// sbsm_rsp_if: translation result channel
// Valid/ready channel carrying one translated ROM offset per request.
// ----------------------------------------------------------------------------
interface sbsm_rsp_if;
  import sbsm_pkg::*;

  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] rom_offset;
  logic                offset_valid;
  logic                is_pattern_rom;
  logic [BANK_W-1:0]   control_value;

  modport source (output valid, rom_offset, offset_valid, is_pattern_rom, control_value,
                  input ready);
  modport sink   (input valid, rom_offset, offset_valid, is_pattern_rom, control_value,
                  output ready);
endinterface

>>> rtl/serial_bank_switch_mapper_top.sv
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_top: serial bank-switch cartridge mapper
// Translates program and pattern bus requests into ROM byte offsets and
// takes bank register loads through a five-bit serial shifter.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one bus request per transfer: program read, program write or
//          pattern read, with the bus address and the written byte.
//   rsp  - one result per request: ROM offset, offset valid flag, pattern
//          ROM flag and the control register after the request.
//   cfg  - cfg_write/cfg_index/cfg_data set the program and pattern ROM
//          sizes and pattern ROM presence; write only while idle.
// A request is first registered in the input register, then translated
// into the result register. Throughput is one request per cycle while
// rsp is not stalled. Under a result stall the input register still
// takes one more request; after that req.ready drops until rsp is
// drained.
// Reset clears the shifter and bank registers, sets the control register
// to program mode 3 and restores the default ROM sizes.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper_top (
  input  logic                          clk,
  input  logic                          rst,
  sbsm_req_if.sink                      req,
  sbsm_rsp_if.source                    rsp,
  input  logic                          cfg_write,
  input  sbsm_pkg::cfg_index_t          cfg_index,
  input  logic [sbsm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sbsm_pkg::*;

  // Configuration registers
  logic [LOG_W-1:0] prg_banks_log2;
  logic [LOG_W-1:0] chr_banks_log2;
  logic             chr_present;

  // Mapper state
  bank_t            shift_bits;
  logic [2:0]       shift_fill;
  bank_t            control_reg;
  bank_t            pattern_bank_lo;
  bank_t            pattern_bank_hi;
  bank_t            program_bank;

  bank_t            shift_bits_next;
  logic [2:0]       shift_fill_next;
  bank_t            control_reg_next;
  bank_t            pattern_bank_lo_next;
  bank_t            pattern_bank_hi_next;
  bank_t            program_bank_next;

  // Input register
  logic               s1_valid;
  req_code_t          s1_type;
  logic [ADDR_W-1:0]  s1_addr;
  logic [VALUE_W-1:0] s1_value;

  logic               out_free;
  logic               s1_advance;

  // Translation results
  logic [OFFSET_W-1:0] offset_next;
  logic                valid_next;
  logic                pattern_next;

  bank_t               prg_mask;
  bank_t               chr_mask;
  bank_t               prg_sel;
  bank_t               chr_bank;
  bank_t               shifted;

  // Handshake: the result register frees when empty or taken
  assign out_free   = !rsp.valid || rsp.ready;
  assign s1_advance = s1_valid && out_free;
  assign req.ready  = !s1_valid || out_free;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_banks_log2 <= 3'd1;
      chr_banks_log2 <= 3'd1;
      chr_present    <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PRG_BANKS_LOG2: prg_banks_log2 <= cfg_data;
        CFG_CHR_BANKS_LOG2: chr_banks_log2 <= cfg_data;
        CFG_CHR_PRESENT:    chr_present    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture request into the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_type  <= req.req_type;
      s1_addr  <= req.bus_address;
      s1_value <= req.write_value;
    end
  end

  // Update the serial shifter and bank registers on a program write
  always_comb begin
    shift_bits_next      = shift_bits;
    shift_fill_next      = shift_fill;
    control_reg_next     = control_reg;
    pattern_bank_lo_next = pattern_bank_lo;
    pattern_bank_hi_next = pattern_bank_hi;
    program_bank_next    = program_bank;
    shifted              = {s1_value[0], shift_bits[BANK_W-1:1]};
    if (s1_type == REQ_PRG_WRITE && s1_addr[15]) begin
      if (s1_value[7]) begin
        shift_bits_next  = '0;
        shift_fill_next  = '0;
        control_reg_next = control_reg | CTRL_PRG_MODE3;
      end else if (shift_fill == 3'd4) begin
        case (s1_addr[14:13])
          2'd0:    control_reg_next     = shifted;
          2'd1:    pattern_bank_lo_next = shifted;
          2'd2:    pattern_bank_hi_next = shifted;
          default: program_bank_next    = shifted;
        endcase
        shift_bits_next  = '0;
        shift_fill_next  = '0;
      end else begin
        shift_bits_next  = shifted;
        shift_fill_next  = shift_fill + 3'd1;
      end
    end
  end

  // Select program bank by mode and address half
  always_comb begin
    prg_mask = bank_limit(prg_banks_log2);
    if (!s1_addr[14]) begin
      case (control_reg[3:2])
        2'd0, 2'd1: prg_sel = {program_bank[4:1], 1'b0};
        2'd2:       prg_sel = '0;
        default:    prg_sel = program_bank;
      endcase
    end else begin
      case (control_reg[3:2])
        2'd0, 2'd1: prg_sel = {program_bank[4:1], 1'b1};
        2'd2:       prg_sel = program_bank;
        default:    prg_sel = prg_mask;
      endcase
    end
    prg_sel = prg_sel & prg_mask;
  end

  // Select pattern bank by 4 KB or 8 KB mode
  always_comb begin
    chr_mask = bank_limit(chr_banks_log2);
    if (!s1_addr[12]) begin
      chr_bank = control_reg[4] ? pattern_bank_lo : {pattern_bank_lo[4:1], 1'b0};
    end else begin
      chr_bank = control_reg[4] ? pattern_bank_hi : {pattern_bank_lo[4:1], 1'b1};
    end
    chr_bank = chr_bank & chr_mask;
  end

  // Form the result fields
  always_comb begin
    offset_next  = '0;
    valid_next   = 1'b0;
    pattern_next = 1'b0;
    case (s1_type)
      REQ_PRG_READ: begin
        if (s1_addr[15]) begin
          offset_next = {prg_sel, s1_addr[13:0]};
          valid_next  = 1'b1;
        end
      end
      REQ_CHR_READ: begin
        if (chr_present && s1_addr[15:13] == 3'd0) begin
          offset_next  = {2'b00, chr_bank, s1_addr[11:0]};
          valid_next   = 1'b1;
          pattern_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Commit state as the request moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_bits      <= '0;
      shift_fill      <= '0;
      control_reg     <= CTRL_PRG_MODE3;
      pattern_bank_lo <= '0;
      pattern_bank_hi <= '0;
      program_bank    <= '0;
    end else if (s1_advance) begin
      shift_bits      <= shift_bits_next;
      shift_fill      <= shift_fill_next;
      control_reg     <= control_reg_next;
      pattern_bank_lo <= pattern_bank_lo_next;
      pattern_bank_hi <= pattern_bank_hi_next;
      program_bank    <= program_bank_next;
    end
  end

  // Hold or advance the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_free) begin
      rsp.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      rsp.rom_offset     <= offset_next;
      rsp.offset_valid   <= valid_next;
      rsp.is_pattern_rom <= pattern_next;
      rsp.control_value  <= control_reg_next;
    end
  end

endmodule
